// ===== rtl/core/dss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// shared types and codes for the dual stack in one shared store
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int WORD_W    = 32;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_TRAV = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               cmd;
    logic                     which_stack;
    logic signed [WORD_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] data_out;
    logic                     last;
  } out_t;

endpackage

// ===== rtl/core/dual_stack_shared_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_shared_store
// two stacks sharing one memory of DEPTH words, lower grows up, upper down
// ----------------------------------------------------------------------------
// usage:
//   a command transfer happens at a clock edge with start high and busy low;
//   in_data carries cmd (push, pop, traverse), which_stack and push_value.
//   results appear on out_data for exactly one cycle with out_valid high;
//   the receiver cannot stall, so every result must be taken when shown.
//   the first result of a command comes in the cycle after its transfer.
//   push and pop give one result and accept a new command every cycle.
//   traverse of n words gives n results on consecutive cycles, top first,
//   last marking the final one; busy is high while the rest are read,
//   since the single memory read port delivers one word per cycle.
//   an empty traverse or pop, or a refused push, gives one result only.
//   an unused command code is taken and gives no result.
//   reset: both stacks empty; memory contents are undefined, no clear pass.
// ----------------------------------------------------------------------------
module dual_stack_shared_store #(
  parameter int DEPTH = dss_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  dss_pkg::in_t  in_data,
  output logic          out_valid,
  output dss_pkg::out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [dss_pkg::WORD_W-1:0] wdata;
  logic                       re;
  logic [AW-1:0]              raddr;
  logic [dss_pkg::WORD_W-1:0] rdata;

  dss_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  dss_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // traverse streams one result every busy cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> out_valid)
    else $error("traverse result missing while busy");

  // while busy the shown result is never the final one
  assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_data.last)
    else $error("final result shown while traverse still running");

  // refused or empty results carry zero data and end the command
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != dss_pkg::ST_OK)
      |-> (out_data.data_out == '0 && out_data.last))
    else $error("bad full or empty result");

  // a push transfer gives its single result in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.cmd == dss_pkg::CMD_PUSH)
      |=> (out_valid && out_data.last && out_data.data_out == '0))
    else $error("push result missing");

endmodule

// ===== rtl/core/dss_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_store
// element memory, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module dss_store #(
  parameter int DEPTH = dss_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [dss_pkg::WORD_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [dss_pkg::WORD_W-1:0] rdata
);

  logic [dss_pkg::WORD_W-1:0] mem [DEPTH];
  logic [dss_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/dss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_ctrl
// stack pointers, command decode and traverse sequencer
// ----------------------------------------------------------------------------
module dss_ctrl #(
  parameter int DEPTH = dss_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  dss_pkg::in_t               in_data,
  output logic                       out_valid,
  output dss_pkg::out_t              out_data,
  output logic                       we,
  output logic [AW-1:0]              waddr,
  output logic [dss_pkg::WORD_W-1:0] wdata,
  output logic                       re,
  output logic [AW-1:0]              raddr,
  input  logic [dss_pkg::WORD_W-1:0] rdata
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_TRAV = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] lower_cnt_r, lower_cnt_nxt;
  logic [CW-1:0] upper_bnd_r, upper_bnd_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          trav_up_r, trav_up_nxt;
  logic          ov_r, ov_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          last_r, last_nxt;
  logic          from_mem_r, from_mem_nxt;

  logic [CW-1:0] lower_dec;
  logic [CW-1:0] upper_dec;
  logic          is_full;
  logic          lower_empty;
  logic          upper_empty;
  logic          ptr_final;

  assign lower_dec   = lower_cnt_r - CW'(1);
  assign upper_dec   = upper_bnd_r - CW'(1);
  assign is_full     = lower_cnt_r >= upper_bnd_r;
  assign lower_empty = lower_cnt_r == '0;
  assign upper_empty = upper_bnd_r >= CW'(DEPTH);
  assign ptr_final   = trav_up_r ? (ptr_r == AW'(DEPTH - 1)) : (ptr_r == '0);

  always_comb begin
    state_nxt     = state_r;
    lower_cnt_nxt = lower_cnt_r;
    upper_bnd_nxt = upper_bnd_r;
    ptr_nxt       = ptr_r;
    trav_up_nxt   = trav_up_r;
    ov_nxt        = 1'b0;
    status_nxt    = status_r;
    last_nxt      = last_r;
    from_mem_nxt  = from_mem_r;
    we            = 1'b0;
    waddr         = lower_cnt_r[AW-1:0];
    wdata         = in_data.push_value;
    re            = 1'b0;
    raddr         = ptr_r;

    if (state_r == S_TRAV) begin
      re           = 1'b1;
      ov_nxt       = 1'b1;
      status_nxt   = dss_pkg::ST_OK;
      from_mem_nxt = 1'b1;
      if (ptr_final) begin
        last_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end else begin
        last_nxt = 1'b0;
        ptr_nxt  = trav_up_r ? ptr_r + AW'(1) : ptr_r - AW'(1);
      end
    end else if (start) begin
      case (in_data.cmd)
        dss_pkg::CMD_PUSH: begin
          ov_nxt       = 1'b1;
          last_nxt     = 1'b1;
          from_mem_nxt = 1'b0;
          if (is_full) begin
            status_nxt = dss_pkg::ST_FULL;
          end else begin
            status_nxt = dss_pkg::ST_OK;
            we         = 1'b1;
            if (in_data.which_stack) begin
              waddr         = upper_dec[AW-1:0];
              upper_bnd_nxt = upper_dec;
            end else begin
              waddr         = lower_cnt_r[AW-1:0];
              lower_cnt_nxt = lower_cnt_r + CW'(1);
            end
          end
        end
        dss_pkg::CMD_POP: begin
          ov_nxt   = 1'b1;
          last_nxt = 1'b1;
          if (in_data.which_stack) begin
            if (upper_empty) begin
              status_nxt   = dss_pkg::ST_EMPTY;
              from_mem_nxt = 1'b0;
            end else begin
              status_nxt    = dss_pkg::ST_OK;
              from_mem_nxt  = 1'b1;
              re            = 1'b1;
              raddr         = upper_bnd_r[AW-1:0];
              upper_bnd_nxt = upper_bnd_r + CW'(1);
            end
          end else begin
            if (lower_empty) begin
              status_nxt   = dss_pkg::ST_EMPTY;
              from_mem_nxt = 1'b0;
            end else begin
              status_nxt    = dss_pkg::ST_OK;
              from_mem_nxt  = 1'b1;
              re            = 1'b1;
              raddr         = lower_dec[AW-1:0];
              lower_cnt_nxt = lower_dec;
            end
          end
        end
        dss_pkg::CMD_TRAV: begin
          ov_nxt = 1'b1;
          if (in_data.which_stack ? upper_empty : lower_empty) begin
            status_nxt   = dss_pkg::ST_EMPTY;
            from_mem_nxt = 1'b0;
            last_nxt     = 1'b1;
          end else begin
            status_nxt   = dss_pkg::ST_OK;
            from_mem_nxt = 1'b1;
            re           = 1'b1;
            trav_up_nxt  = in_data.which_stack;
            if (in_data.which_stack) begin
              raddr    = upper_bnd_r[AW-1:0];
              ptr_nxt  = upper_bnd_r[AW-1:0] + AW'(1);
              last_nxt = upper_bnd_r == CW'(DEPTH - 1);
            end else begin
              raddr    = lower_dec[AW-1:0];
              ptr_nxt  = lower_dec[AW-1:0] - AW'(1);
              last_nxt = lower_cnt_r == CW'(1);
            end
            if (!last_nxt) begin
              state_nxt = S_TRAV;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lower_cnt_r <= '0;
      upper_bnd_r <= CW'(DEPTH);
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lower_cnt_r <= lower_cnt_nxt;
      upper_bnd_r <= upper_bnd_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    trav_up_r  <= trav_up_nxt;
    status_r   <= status_nxt;
    last_r     <= last_nxt;
    from_mem_r <= from_mem_nxt;
  end

  assign busy              = state_r == S_TRAV;
  assign out_valid         = ov_r;
  assign out_data.status   = status_r;
  assign out_data.data_out = from_mem_r ? rdata : '0;
  assign out_data.last     = last_r;

endmodule
